>>> rtl/core/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// shared types and constants of the countdown timer tick converter
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int RATE_W     = 32;
  localparam int DIV_W      = 20;   // holds the largest divisor, one million
  localparam int DIV_CNT_W  = 6;    // one quotient bit per step, WORD_W steps

  localparam logic [RATE_W-1:0] RATE_RESET  = 32'd1000;
  localparam logic [RATE_W-1:0] RATE_US_LIM = 32'd1000;
  localparam logic [DIV_W-1:0]  US_PER_S    = 20'd1000000;
  localparam logic [DIV_W-1:0]  MS_PER_S    = 20'd1000;
  localparam logic [DIV_W-1:0]  US_PER_MS   = 20'd1000;

  typedef enum logic [2:0] {
    REQ_RESTART = 3'd0,
    REQ_READ    = 3'd1,
    REQ_SET_US  = 3'd2,
    REQ_SET_MS  = 3'd3,
    REQ_CHECK   = 3'd4
  } req_t;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

endpackage

>>> rtl/core/ctt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_mul
// 32 x 32 multiplier with a registered product
// ----------------------------------------------------------------------------
module ctt_mul import ctt_pkg::*; (
  input  logic              clk,
  input  logic [HALF_W-1:0] a,
  input  logic [RATE_W-1:0] b,
  output logic [WORD_W-1:0] p
);

  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] p_r;

  assign prod = {{(WORD_W-HALF_W){1'b0}}, a} * {{(WORD_W-RATE_W){1'b0}}, b};

  always_ff @(posedge clk) begin
    p_r <= prod;
  end

  assign p = p_r;

endmodule

>>> rtl/core/ctt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_div
// restoring divider, 64-bit dividend by a narrow divisor, one bit per cycle
// ----------------------------------------------------------------------------
module ctt_div import ctt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [WORD_W-1:0]    quo_r;
  logic [DIV_W-1:0]     dsr_r;

  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 take;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign take    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[WORD_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/countdown_timer_tick_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_tick_converter
// start mark, elapsed read and countdown deadline beside a free-running timer
// ----------------------------------------------------------------------------
// sequence: restart, read, check and unused codes go from decode straight to the
//   result; a set runs k+1 multiply rounds for k halving rounds (0..19, at most 9
//   for milliseconds) and then the 64-step divide, an overflow gives up after its
//   last round; a microsecond set at a rate of 1000 Hz or less first runs the pre-scale divide
// throughput: one beat at a time, the next accepted the cycle after the result
//   is loaded; a set is held up by the 64-step divider and its multiply rounds
// reset: synchronous active low; rate back to 1000 Hz, start mark and
//   deadline cleared, output empty
module countdown_timer_tick_converter import ctt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_tick_rate_hz,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [WORD_W-1:0] in_now_ticks,
  input  logic [WORD_W-1:0] in_duration,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_elapsed_ticks,
  output logic              out_countdown_done,
  output logic              out_overflow_error
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREDIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK,
    ST_DIVIDE,
    ST_RESP
  } state_t;

  state_t            state_r;
  logic [RATE_W-1:0] rate_r;
  logic [WORD_W-1:0] start_mark_r;
  logic [WORD_W-1:0] deadline_r;

  // latched request beat
  logic [2:0]        req_r;
  logic [WORD_W-1:0] now_r;
  logic [WORD_W-1:0] dur_r;
  logic [DIV_W-1:0]  div_r;
  logic [WORD_W-1:0] plo_r;

  // pending result, then the output register
  logic [WORD_W-1:0] res_elapsed_r;
  logic              res_done_r;
  logic              res_err_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_elapsed_r;
  logic              out_done_r;
  logic              out_err_r;

  // shared units
  logic [HALF_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_p;
  div_req_t          div_req;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  // product of the current round: {sum, plo_r[31:0]} is 97 bits wide
  logic [WORD_W:0]   sum;
  logic              ovf;
  logic              slot_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  assign sum = {1'b0, mul_p} + {{(WORD_W-HALF_W+1){1'b0}}, plo_r[WORD_W-1:HALF_W]};
  assign ovf = |sum[WORD_W:HALF_W];

  // low half of the duration first, then the high half
  assign mul_a = (state_r == ST_MUL_HI) ? dur_r[WORD_W-1:HALF_W] : dur_r[HALF_W-1:0];

  // divider serves the microsecond pre-scale and the final tick division
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = dur_r;
    div_req.divisor  = US_PER_MS;
    if (state_r == ST_DECODE) begin
      div_req.start = (req_r == REQ_SET_US) && (rate_r <= RATE_US_LIM);
    end else if (state_r == ST_CHECK) begin
      div_req.start    = !ovf;
      div_req.dividend = {sum[HALF_W-1:0], plo_r[HALF_W-1:0]};
      div_req.divisor  = div_r;
    end
  end

  ctt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (rate_r),
    .p   (mul_p)
  );

  ctt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // control, architectural state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= RATE_RESET;
      start_mark_r <= '0;
      deadline_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_tick_rate_hz;
      end
      // beat taken with no new one behind it
      if (out_valid_r && out_ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (req_r)
            REQ_RESTART: begin
              start_mark_r <= now_r;
              state_r      <= ST_RESP;
            end
            REQ_SET_US: begin
              state_r <= (rate_r <= RATE_US_LIM) ? ST_PREDIV : ST_MUL_LO;
            end
            REQ_SET_MS: state_r <= ST_MUL_LO;
            default:    state_r <= ST_RESP;
          endcase
        end
        ST_PREDIV: begin
          if (div_done) begin
            state_r <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: state_r <= ST_MUL_HI;
        ST_MUL_HI: state_r <= ST_CHECK;
        ST_CHECK: begin
          if (!ovf) begin
            state_r <= ST_DIVIDE;
          end else if (div_r <= DIV_W'(1)) begin
            // divisor already one: give up, state untouched
            state_r <= ST_RESP;
          end else begin
            state_r <= ST_MUL_LO;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            start_mark_r <= now_r;
            deadline_r   <= now_r + div_q;
            state_r      <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_req_type;
      now_r <= in_now_ticks;
      dur_r <= in_duration;
    end
    case (state_r)
      ST_DECODE: begin
        res_elapsed_r <= (req_r == REQ_READ) ? now_r - start_mark_r : '0;
        res_done_r    <= (req_r == REQ_CHECK) && (now_r > deadline_r);
        res_err_r     <= 1'b0;
        div_r         <= (req_r == REQ_SET_US && rate_r > RATE_US_LIM) ? US_PER_S
                                                                        : MS_PER_S;
      end
      ST_PREDIV: begin
        if (div_done) begin
          dur_r <= div_q;
        end
      end
      ST_MUL_HI: plo_r <= mul_p;
      ST_CHECK: begin
        if (ovf) begin
          if (div_r <= DIV_W'(1)) begin
            res_err_r <= 1'b1;
          end else begin
            dur_r <= dur_r >> 1;
            div_r <= div_r >> 1;
          end
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_elapsed_r <= res_elapsed_r;
          out_done_r    <= res_done_r;
          out_err_r     <= res_err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_elapsed_ticks  = out_elapsed_r;
  assign out_countdown_done = out_done_r;
  assign out_overflow_error = out_err_r;

  // the divider only finishes while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_PREDIV || state_r == ST_DIVIDE))
    else $error("divider finished outside a wait state");

  // halving never drives the divisor to zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> div_r != '0)
    else $error("tick divisor reached zero");

  // an error beat carries no other result
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow_error) |-> (!out_countdown_done && out_elapsed_ticks == '0))
    else $error("overflow beat carries other results");

  // a failed conversion leaves the deadline alone
  a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && res_err_r) |-> $stable(deadline_r))
    else $error("deadline changed on a failed conversion");

endmodule
